// ----- rtl/sd_spi_command_data_engine_unit_macros.svh -----
// assertion macros for the sd spi engine
`ifndef SD_SPI_COMMAND_DATA_ENGINE_UNIT_MACROS_SVH
`define SD_SPI_COMMAND_DATA_ENGINE_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SDE_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define SDE_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- rtl/sde_pkg.sv -----
// package with types, codes and constants of the sd spi engine
package sde_pkg;
  localparam logic [3:0] RespTries = 4'd10;
  localparam logic [3:0] DataRespTries = 4'd4;
  localparam logic [9:0] WriteBlockBytes = 10'd512;

  typedef enum logic [2:0] {
    CMD_ISSUE = 3'd0, CMD_DATA = 3'd1, CMD_CARD = 3'd2,
    CMD_WDATA = 3'd3, CMD_TICK = 3'd4, CMD_REL = 3'd5
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DESEL, PH_SELDUM, PH_READY, PH_SELFAIL, PH_FRAME, PH_SKIP,
    PH_R1, PH_TOKWAIT, PH_RDATA, PH_CRC1, PH_CRC2, PH_WREADY, PH_WTOKEN,
    PH_WNEED, PH_WDATA, PH_WRESP
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_READY = 3'd1, ST_NO_RESP = 3'd2, ST_CMD_ERR = 3'd3,
    ST_TOKEN_FAIL = 3'd4, ST_REJECTED = 3'd5, ST_WBUSY = 3'd6
  } status_e;

  localparam logic [1:0] DP_NONE = 2'd0;
  localparam logic [1:0] DP_READ = 2'd1;
  localparam logic [1:0] DP_STOP = 2'd3;

  localparam logic [0:0] REG_READY_TO = 1'b0;
  localparam logic [0:0] REG_TOKEN_TO = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  cmd_index;
    logic        app_cmd;
    logic [31:0] argument;
    logic [1:0]  data_phase;
    logic [9:0]  block_len;
    logic [7:0]  write_token;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_write_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] response;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ready_to;
    logic [7:0] token_to;
  } cfg_t;
endpackage

// ----- rtl/sde_cfg_regs.sv -----
// apb configuration registers of the sd spi engine
module sde_cfg_regs import sde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  logic [7:0] ready_to_q, token_to_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_to_q <= 8'd1;
      token_to_q <= 8'd2;
    end else if (psel && penable && pwrite) begin
      if (paddr == {REG_READY_TO, 2'b00}) ready_to_q <= pwdata[7:0];
      else if (paddr == {REG_TOKEN_TO, 2'b00}) token_to_q <= pwdata[7:0];
    end
  end
  always_comb begin
    case (paddr)
      {REG_READY_TO, 2'b00}: prdata = {24'd0, ready_to_q};
      {REG_TOKEN_TO, 2'b00}: prdata = {24'd0, token_to_q};
      default: prdata = 32'd0;
    endcase
  end
  assign pready = 1'b1;
  assign cfg_o = '{ready_to: ready_to_q, token_to: token_to_q};
endmodule

// ----- rtl/sde_engine.sv -----
// protocol sequencer: one input transfer in, at most one result out
module sde_engine import sde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
`include "sd_spi_command_data_engine_unit_macros.svh"
  phase_e phase_q, phase_d;
  logic [9:0] cnt_q, cnt_d, len_q, len_d;
  logic [3:0] retry_q, retry_d;
  logic [7:0] timer_q, timer_d, resp_q, resp_d, tok_q, tok_d;
  logic [5:0] idx_q, idx_d;
  logic pre_q, pre_d, sel_q, sel_d;
  logic [31:0] arg_q, arg_d;
  logic [1:0] hph_q, hph_d;
  logic ov_q, ov_d;
  out_item_t od_q, od_d;
  logic acc, emit;
  logic [7:0] tx, rd;
  logic txv, rdv, need, done;
  logic [2:0] st;
  logic [5:0] ci;
  logic [31:0] ca;
  logic [7:0] rx;

  assign in_ready_o = !ov_q || out_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign rx = in_data_i.rx_byte;

  function automatic logic [7:0] frame(input logic [2:0] k, input logic [5:0] i,
                                       input logic [31:0] a);
    case (k)
      3'd0: frame = 8'h40 | {2'b00, i};
      3'd1: frame = a[31:24];
      3'd2: frame = a[23:16];
      3'd3: frame = a[15:8];
      3'd4: frame = a[7:0];
      default: frame = (i == 6'd0) ? 8'h95 : ((i == 6'd8) ? 8'h87 : 8'h01);
    endcase
  endfunction

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; retry_d = retry_q; timer_d = timer_q;
    idx_d = idx_q; pre_d = pre_q; arg_d = arg_q; resp_d = resp_q; hph_d = hph_q;
    len_d = len_q; tok_d = tok_q; sel_d = sel_q;
    emit = 1'b0; tx = 8'h00; txv = 1'b0; rd = 8'h00; rdv = 1'b0; need = 1'b0;
    done = 1'b0; st = ST_OK;
    ci = pre_q ? 6'd55 : idx_q;
    ca = pre_q ? 32'd0 : arg_q;
    if (acc) begin
      case (in_data_i.command)
        CMD_ISSUE: if (phase_q == PH_IDLE) begin
          idx_d = in_data_i.cmd_index; pre_d = in_data_i.app_cmd;
          arg_d = in_data_i.argument; hph_d = in_data_i.data_phase;
          len_d = in_data_i.block_len; tok_d = in_data_i.write_token;
          resp_d = 8'hFF; emit = 1'b1; txv = 1'b1;
          ci = pre_d ? 6'd55 : idx_d;
          ca = pre_d ? 32'd0 : arg_d;
          if (ci == 6'd12) begin
            cnt_d = 10'd0; phase_d = PH_FRAME; tx = frame(3'd0, ci, ca);
          end else begin
            sel_d = 1'b0; phase_d = PH_DESEL; tx = 8'hFF;
          end
        end
        CMD_DATA: if (phase_q == PH_IDLE) begin
          hph_d = in_data_i.data_phase; len_d = in_data_i.block_len;
          tok_d = in_data_i.write_token; emit = 1'b1;
          if (hph_d == DP_READ) begin
            timer_d = cfg_i.token_to; phase_d = PH_TOKWAIT; tx = 8'hFF; txv = 1'b1;
          end else if (hph_d != DP_NONE) begin
            timer_d = cfg_i.ready_to; phase_d = PH_WREADY; tx = 8'hFF; txv = 1'b1;
          end else begin
            phase_d = PH_IDLE; pre_d = 1'b0; done = 1'b1;
          end
        end
        CMD_CARD: begin
          emit = (phase_q != PH_IDLE) && (phase_q != PH_WNEED);
          tx = 8'hFF; txv = 1'b1;
          case (phase_q)
            PH_DESEL: begin sel_d = 1'b1; phase_d = PH_SELDUM; end
            PH_SELDUM: begin timer_d = cfg_i.ready_to; phase_d = PH_READY; end
            PH_READY: begin
              if (rx == 8'hFF) begin
                cnt_d = 10'd0; phase_d = PH_FRAME; tx = frame(3'd0, ci, ca);
              end else if (timer_q == 8'd0) begin
                sel_d = 1'b0; phase_d = PH_SELFAIL;
              end
            end
            PH_SELFAIL: begin
              resp_d = 8'hFF; phase_d = PH_IDLE; pre_d = 1'b0;
              txv = 1'b0; tx = 8'h00; done = 1'b1; st = ST_NOT_READY;
            end
            PH_FRAME: begin
              cnt_d = cnt_q + 10'd1;
              if (cnt_d < 10'd6) tx = frame(cnt_d[2:0], ci, ca);
              else if (ci == 6'd12) phase_d = PH_SKIP;
              else begin retry_d = RespTries; phase_d = PH_R1; end
            end
            PH_SKIP: begin retry_d = RespTries; phase_d = PH_R1; end
            PH_R1: begin
              if (rx[7] && retry_q > 4'd1) retry_d = retry_q - 4'd1;
              else begin
                resp_d = rx;
                txv = 1'b0; tx = 8'h00; done = 1'b1; phase_d = PH_IDLE;
                pre_d = 1'b0;
                if (pre_q) begin
                  if (rx > 8'd1) st = rx[7] ? ST_NO_RESP : ST_CMD_ERR;
                  else begin
                    done = 1'b0; txv = 1'b1;
                    if (idx_q == 6'd12) begin
                      cnt_d = 10'd0; phase_d = PH_FRAME;
                      tx = frame(3'd0, idx_q, arg_q);
                    end else begin
                      sel_d = 1'b0; phase_d = PH_DESEL; tx = 8'hFF;
                    end
                  end
                end else if (rx[7]) st = ST_NO_RESP;
                else if (hph_q == DP_NONE) st = ST_OK;
                else if (rx != 8'd0) st = ST_CMD_ERR;
                else begin
                  done = 1'b0; txv = 1'b1; tx = 8'hFF;
                  if (hph_q == DP_READ) begin
                    timer_d = cfg_i.token_to; phase_d = PH_TOKWAIT;
                  end else begin
                    timer_d = cfg_i.ready_to; phase_d = PH_WREADY;
                  end
                end
              end
            end
            PH_TOKWAIT: begin
              if (!(rx == 8'hFF && timer_q != 8'd0)) begin
                if (rx != 8'hFE) begin
                  txv = 1'b0; tx = 8'h00; done = 1'b1; st = ST_TOKEN_FAIL;
                  phase_d = PH_IDLE; pre_d = 1'b0;
                end else begin
                  cnt_d = 10'd0;
                  phase_d = (len_q == 10'd0) ? PH_CRC1 : PH_RDATA;
                end
              end
            end
            PH_RDATA: begin
              if ({1'b0, cnt_q} + 11'd1 >= {1'b0, len_q}) phase_d = PH_CRC1;
              else cnt_d = cnt_q + 10'd1;
              rd = rx; rdv = 1'b1;
            end
            PH_CRC1: phase_d = PH_CRC2;
            PH_CRC2: begin
              txv = 1'b0; tx = 8'h00; done = 1'b1; phase_d = PH_IDLE; pre_d = 1'b0;
            end
            PH_WREADY: begin
              if (rx == 8'hFF) begin
                phase_d = PH_WTOKEN; tx = (hph_q == DP_STOP) ? 8'hFD : tok_q;
              end else if (timer_q == 8'd0) begin
                txv = 1'b0; tx = 8'h00; done = 1'b1; st = ST_WBUSY;
                phase_d = PH_IDLE; pre_d = 1'b0;
              end
            end
            PH_WTOKEN: begin
              txv = 1'b0; tx = 8'h00;
              if (hph_q == DP_STOP || tok_q == 8'hFD) begin
                done = 1'b1; phase_d = PH_IDLE; pre_d = 1'b0;
              end else begin
                cnt_d = 10'd0; phase_d = PH_WNEED; need = 1'b1;
              end
            end
            PH_WDATA: begin
              if ({1'b0, cnt_q} + 11'd1 < {1'b0, WriteBlockBytes}) begin
                cnt_d = cnt_q + 10'd1; phase_d = PH_WNEED;
                txv = 1'b0; tx = 8'h00; need = 1'b1;
              end else begin
                retry_d = DataRespTries; phase_d = PH_WRESP;
              end
            end
            PH_WRESP: begin
              if ((rx & 8'h1F) == 8'h05) begin
                txv = 1'b0; tx = 8'h00; done = 1'b1; phase_d = PH_IDLE; pre_d = 1'b0;
              end else if (retry_q > 4'd1) retry_d = retry_q - 4'd1;
              else begin
                txv = 1'b0; tx = 8'h00; done = 1'b1; st = ST_REJECTED;
                phase_d = PH_IDLE; pre_d = 1'b0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
        CMD_WDATA: if (phase_q == PH_WNEED) begin
          phase_d = PH_WDATA; emit = 1'b1; tx = in_data_i.tx_data; txv = 1'b1;
        end
        CMD_TICK: if (timer_q != 8'd0) timer_d = timer_q - 8'd1;
        CMD_REL: begin
          phase_d = PH_IDLE; pre_d = 1'b0; sel_d = 1'b0;
          emit = 1'b1; tx = 8'hFF; txv = 1'b1;
        end
        default: emit = 1'b0;
      endcase
    end
    ov_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);
    od_d = od_q;
    if (emit) od_d = '{tx_byte: tx, tx_valid: txv, chip_select_low: sel_d, read_byte: rd,
                       read_valid: rdv, need_write_byte: need, done_res: done,
                       status: st, response: resp_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cnt_q <= '0; retry_q <= '0; timer_q <= '0; idx_q <= '0;
      pre_q <= 1'b0; arg_q <= '0; resp_q <= 8'hFF; hph_q <= '0; len_q <= '0;
      tok_q <= '0; sel_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; retry_q <= retry_d; timer_q <= timer_d;
      idx_q <= idx_d; pre_q <= pre_d; arg_q <= arg_d; resp_q <= resp_d; hph_q <= hph_d;
      len_q <= len_d; tok_q <= tok_d; sel_q <= sel_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) od_q <= od_d;

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  `SDE_ASSERT_NXT(a_rel_idle, clk_i, rst_ni, acc && in_data_i.command == CMD_REL,
                  phase_q == PH_IDLE && !sel_q)
  `SDE_ASSERT_IMP(a_need_phase, clk_i, rst_ni, phase_q == PH_WNEED, !pre_q)
  `SDE_ASSERT_IMP(a_done_notx, clk_i, rst_ni, ov_q && od_q.done_res,
                  !od_q.tx_valid && !od_q.read_valid)
  `SDE_ASSERT_IMP(a_st_done, clk_i, rst_ni, ov_q && !od_q.done_res, od_q.status == ST_OK)
endmodule

// ----- rtl/sd_spi_command_data_engine_unit.sv -----
// latency: a result appears in the cycle after its input transfer is accepted
// throughput: one transfer per cycle if not stalled, one result register between the sides
// an input transfer is taken while a result waits if that result is taken in the same cycle
// reset: asynchronous active-low rst_ni clears the sequencer to idle with chip select
// released, response 0xff and timeouts at 1 and 2 ticks
// top level of the sd spi command and data engine
module sd_spi_command_data_engine_unit import sde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);
  cfg_t cfg;
  sde_cfg_regs u_cfg (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                      .prdata, .pready, .cfg_o(cfg));
  sde_engine u_eng (.clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_ready_o, .in_data_i,
                    .out_valid_o, .out_ready_i, .out_data_o);
endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the sd spi command and data engine
module tb_top;
  import sde_pkg::*;

  localparam logic [1:0] DP_WRITE = 2'd2;
  localparam logic [7:0] TOK_SINGLE = 8'hFE;
  localparam logic [7:0] TOK_MULTI = 8'hFC;
  localparam logic [7:0] TOK_STOP = 8'hFD;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    phase_e     ph;
    logic [9:0] cnt;
    logic [3:0] retry;
    logic [7:0] timer;
    logic [5:0] idx;
    logic       pre;
    logic [31:0] arg;
    logic [7:0] resp;
    logic [1:0] dp;
    logic [9:0] len;
    logic [7:0] tok;
    logic       cs;
    logic [7:0] rto;
    logic [7:0] tto;
  } engine_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;

  engine_t     engine;      // tracks the block at each accepted transfer
  engine_t     plan;        // tracks the block while stimulus is built
  in_item_t    pending_xfers[$];
  out_item_t   predicted_results[$];
  int          errors = 0, cycles = 0, n_in = 0, n_out = 0, n_done = 0, n_reads = 0;
  int          in_gap = 0, out_gap = 0, hold_left = 0;
  bit          took = 1'b0, quiet = 1'b0, want_hold = 1'b0;

  sd_spi_command_data_engine_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic out_item_t pack_res(engine_t s, logic [7:0] tx, logic txv,
      logic [7:0] rd, logic rdv, logic need, logic dn, logic [2:0] st);
    out_item_t o;
    o.tx_byte = tx; o.tx_valid = txv; o.chip_select_low = s.cs;
    o.read_byte = rd; o.read_valid = rdv; o.need_write_byte = need;
    o.done_res = dn; o.status = st; o.response = s.resp;
    return o;
  endfunction

  function automatic out_item_t dummy_clock(engine_t s);
    return pack_res(s, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
  endfunction

  function automatic out_item_t wrap_up(inout engine_t s, input status_e st);
    s.ph = PH_IDLE;
    s.pre = 1'b0;
    return pack_res(s, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, st);
  endfunction

  function automatic logic [5:0] cur_idx(engine_t s);
    return s.pre ? 6'd55 : s.idx;
  endfunction

  function automatic logic [7:0] frame_byte(engine_t s, int k);
    logic [5:0]  i;
    logic [31:0] a;
    i = cur_idx(s);
    a = s.pre ? 32'd0 : s.arg;
    case (k)
      0: return {2'b01, i};
      1: return a[31:24];
      2: return a[23:16];
      3: return a[15:8];
      4: return a[7:0];
      default: return (i == 6'd0) ? 8'h95 : ((i == 6'd8) ? 8'h87 : 8'h01);
    endcase
  endfunction

  function automatic out_item_t start_cmd(inout engine_t s);
    if (cur_idx(s) == 6'd12) begin
      s.cnt = '0;
      s.ph = PH_FRAME;
      return pack_res(s, frame_byte(s, 0), 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
    end
    s.cs = 1'b0;
    s.ph = PH_DESEL;
    return dummy_clock(s);
  endfunction

  function automatic out_item_t start_data(inout engine_t s);
    if (s.dp == DP_READ) begin
      s.timer = s.tto;
      s.ph = PH_TOKWAIT;
      return dummy_clock(s);
    end
    if (s.dp >= DP_WRITE) begin
      s.timer = s.rto;
      s.ph = PH_WREADY;
      return dummy_clock(s);
    end
    return wrap_up(s, ST_OK);
  endfunction

  function automatic out_item_t answer(inout engine_t s, input logic [7:0] r);
    s.resp = r;
    if (s.pre) begin
      if (r > 8'd1) return wrap_up(s, r[7] ? ST_NO_RESP : ST_CMD_ERR);
      s.pre = 1'b0;
      return start_cmd(s);
    end
    if (r[7]) return wrap_up(s, ST_NO_RESP);
    if (s.dp == DP_NONE) return wrap_up(s, ST_OK);
    if (r != 8'd0) return wrap_up(s, ST_CMD_ERR);
    return start_data(s);
  endfunction

  function automatic bit card_byte(inout engine_t s, input logic [7:0] rx,
      output out_item_t o);
    case (s.ph)
      PH_DESEL: begin
        s.cs = 1'b1; s.ph = PH_SELDUM; o = dummy_clock(s);
      end
      PH_SELDUM: begin
        s.timer = s.rto; s.ph = PH_READY; o = dummy_clock(s);
      end
      PH_READY: begin
        if (rx == 8'hFF) begin
          s.cnt = '0; s.ph = PH_FRAME;
          o = pack_res(s, frame_byte(s, 0), 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
        end else begin
          if (s.timer == 8'd0) begin
            s.cs = 1'b0; s.ph = PH_SELFAIL;
          end
          o = dummy_clock(s);
        end
      end
      PH_SELFAIL: begin
        s.resp = 8'hFF; o = wrap_up(s, ST_NOT_READY);
      end
      PH_FRAME: begin
        s.cnt++;
        if (s.cnt < 10'd6)
          o = pack_res(s, frame_byte(s, int'(s.cnt)), 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
        else if (cur_idx(s) == 6'd12) begin
          s.ph = PH_SKIP; o = dummy_clock(s);
        end else begin
          s.retry = RespTries; s.ph = PH_R1; o = dummy_clock(s);
        end
      end
      PH_SKIP: begin
        s.retry = RespTries; s.ph = PH_R1; o = dummy_clock(s);
      end
      PH_R1: begin
        if (rx[7] && s.retry > 4'd1) begin
          s.retry--; o = dummy_clock(s);
        end else o = answer(s, rx);
      end
      PH_TOKWAIT: begin
        if (rx == 8'hFF && s.timer != 8'd0) o = dummy_clock(s);
        else if (rx != TOK_SINGLE) o = wrap_up(s, ST_TOKEN_FAIL);
        else begin
          s.cnt = '0;
          s.ph = (s.len == 10'd0) ? PH_CRC1 : PH_RDATA;
          o = dummy_clock(s);
        end
      end
      PH_RDATA: begin
        if (int'(s.cnt) + 1 >= int'(s.len)) s.ph = PH_CRC1;
        else s.cnt++;
        o = pack_res(s, 8'hFF, 1'b1, rx, 1'b1, 1'b0, 1'b0, ST_OK);
      end
      PH_CRC1: begin
        s.ph = PH_CRC2; o = dummy_clock(s);
      end
      PH_CRC2: o = wrap_up(s, ST_OK);
      PH_WREADY: begin
        if (rx == 8'hFF) begin
          s.ph = PH_WTOKEN;
          o = pack_res(s, (s.dp == DP_STOP) ? TOK_STOP : s.tok, 1'b1, 8'h00, 1'b0,
                       1'b0, 1'b0, ST_OK);
        end else if (s.timer == 8'd0) o = wrap_up(s, ST_WBUSY);
        else o = dummy_clock(s);
      end
      PH_WTOKEN: begin
        if (s.dp == DP_STOP || s.tok == TOK_STOP) o = wrap_up(s, ST_OK);
        else begin
          s.cnt = '0; s.ph = PH_WNEED;
          o = pack_res(s, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
        end
      end
      PH_WDATA: begin
        if (int'(s.cnt) + 1 < int'(WriteBlockBytes)) begin
          s.cnt++; s.ph = PH_WNEED;
          o = pack_res(s, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
        end else begin
          s.retry = DataRespTries; s.ph = PH_WRESP; o = dummy_clock(s);
        end
      end
      PH_WRESP: begin
        if (rx[4:0] == 5'h05) o = wrap_up(s, ST_OK);
        else if (s.retry > 4'd1) begin
          s.retry--; o = dummy_clock(s);
        end else o = wrap_up(s, ST_REJECTED);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit engine_step(inout engine_t s, input in_item_t it,
      output out_item_t o);
    o = '0;
    case (it.command)
      CMD_ISSUE: begin
        if (s.ph != PH_IDLE) return 1'b0;
        s.idx = it.cmd_index; s.pre = it.app_cmd; s.arg = it.argument;
        s.dp = it.data_phase; s.len = it.block_len; s.tok = it.write_token;
        s.resp = 8'hFF;
        o = start_cmd(s);
        return 1'b1;
      end
      CMD_DATA: begin
        if (s.ph != PH_IDLE) return 1'b0;
        s.dp = it.data_phase; s.len = it.block_len; s.tok = it.write_token;
        o = start_data(s);
        return 1'b1;
      end
      CMD_CARD: return card_byte(s, it.rx_byte, o);
      CMD_WDATA: begin
        if (s.ph != PH_WNEED) return 1'b0;
        s.ph = PH_WDATA;
        o = pack_res(s, it.tx_data, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK);
        return 1'b1;
      end
      CMD_TICK: begin
        if (s.timer != 8'd0) s.timer--;
        return 1'b0;
      end
      CMD_REL: begin
        s.ph = PH_IDLE; s.pre = 1'b0; s.cs = 1'b0;
        o = dummy_clock(s);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic engine_t engine_reset();
    engine_t s;
    s.ph = PH_IDLE; s.cnt = '0; s.retry = '0; s.timer = '0; s.idx = '0; s.pre = 1'b0;
    s.arg = '0; s.resp = 8'hFF; s.dp = DP_NONE; s.len = '0; s.tok = '0; s.cs = 1'b0;
    s.rto = 8'd1; s.tto = 8'd2;
    return s;
  endfunction

  function automatic in_item_t rand_item(logic [2:0] c);
    in_item_t    it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.command = c;
    return it;
  endfunction

  task automatic push(in_item_t it);
    out_item_t d;
    void'(engine_step(plan, it, d));
    pending_xfers.push_back(it);
  endtask

  // card byte that steers the sequence toward its interesting paths
  function automatic logic [7:0] pick_rx(engine_t s);
    int r;
    r = $urandom_range(0, 9);
    case (s.ph)
      PH_READY, PH_WREADY: return (r < 7) ? 8'hFF : 8'($urandom_range(0, 254));
      PH_R1: begin
        if (r < 2) return 8'h80 | 8'($urandom);
        if (r < 7) return 8'h00;
        if (r < 9) return 8'h01;
        return 8'($urandom);
      end
      PH_TOKWAIT: begin
        if (r < 2) return 8'hFF;
        if (r < 8) return TOK_SINGLE;
        return 8'($urandom);
      end
      PH_WRESP: return (r < 5) ? {3'($urandom), 5'h05} : 8'($urandom);
      default: return 8'($urandom);
    endcase
  endfunction

  // a block write is cut short by a release after four data bytes
  task automatic request(logic [2:0] c, logic [5:0] idx, logic app, logic [1:0] dp,
      logic [9:0] len, logic [7:0] tok);
    in_item_t it;
    int guard;
    it = rand_item(c);
    it.cmd_index = idx; it.app_cmd = app; it.data_phase = dp;
    it.block_len = len; it.write_token = tok;
    push(it);
    guard = 0;
    while (plan.ph != PH_IDLE && guard < 1500) begin
      guard++;
      if (plan.ph == PH_WNEED && plan.cnt >= 10'd4) break;
      if ($urandom_range(0, 59) == 0)
        push(rand_item(3'($urandom_range(0, 7))));
      else if (plan.ph == PH_WNEED)
        push(rand_item(CMD_WDATA));
      else begin
        if ((plan.ph == PH_READY || plan.ph == PH_TOKWAIT || plan.ph == PH_WREADY)
            && $urandom_range(0, 2) == 0)
          push(rand_item(CMD_TICK));
        it = rand_item(CMD_CARD);
        it.rx_byte = pick_rx(plan);
        push(it);
      end
    end
    if (plan.ph != PH_IDLE) push(rand_item(CMD_REL));
  endtask

  task automatic random_request();
    logic [5:0] idx;
    logic [1:0] dp;
    logic [9:0] len;
    logic [7:0] tok;
    int r;
    r = $urandom_range(0, 9);
    idx = (r < 2) ? 6'd0 : (r < 3) ? 6'd8 : (r < 4) ? 6'd12 : 6'($urandom);
    r = $urandom_range(0, 19);
    dp = (r < 7) ? DP_NONE : (r < 14) ? DP_READ : (r < 17) ? DP_WRITE : DP_STOP;
    r = $urandom_range(0, 9);
    len = (r == 0) ? 10'd0 : 10'($urandom_range(1, 12));
    tok = ($urandom_range(0, 3) == 0) ? 8'($urandom) : TOK_STOP;
    request(($urandom_range(0, 7) == 0) ? CMD_DATA : CMD_ISSUE, idx,
            $urandom_range(0, 3) == 0, dp, len, tok);
  endtask

  task automatic drain();
    while (pending_xfers.size() != 0 || predicted_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [0:0] regsel, logic [7:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {regsel, 2'b00}; pwdata <= {24'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(logic [7:0] rto, logic [7:0] tto);
    drain();
    apb_write(REG_READY_TO, rto);
    apb_write(REG_TOKEN_TO, tto);
    engine.rto = rto; engine.tto = tto;
    plan.rto = rto; plan.tto = tto;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || took) begin
        took = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else if (pending_xfers.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_xfers[0];
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 150;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : mon
    out_item_t e, r;
    in_item_t  it;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (predicted_results.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer out: expected none, got %h", $realtime,
                 out_data_o);
      end else begin
        e = predicted_results.pop_front();
        if (e !== out_data_o) begin
          errors++;
          $display("%0t mismatch: expected %h, got %h", $realtime, e, out_data_o);
        end
        if (e.done_res) n_done++;
        if (e.read_valid) n_reads++;
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      took = 1'b1;
      n_in++;
      it = pending_xfers.pop_front();
      if (engine_step(engine, it, r)) predicted_results.push_back(r);
    end
  end

  initial begin : stim
    int k, wait_c;
    engine = engine_reset();
    plan = engine_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests at reset timeouts
    push(rand_item(CMD_CARD));
    push(rand_item(CMD_WDATA));
    push(rand_item(3'd6));
    push(rand_item(3'd7));
    push(rand_item(CMD_TICK));
    request(CMD_ISSUE, 6'd0, 1'b0, DP_NONE, 10'd0, 8'h00);
    request(CMD_ISSUE, 6'd8, 1'b0, DP_NONE, 10'd0, 8'h00);
    request(CMD_ISSUE, 6'd63, 1'b1, DP_READ, 10'd3, 8'h00);
    request(CMD_ISSUE, 6'd12, 1'b0, DP_READ, 10'd0, 8'h00);
    request(CMD_DATA, 6'd0, 1'b0, DP_NONE, 10'd0, 8'h00);
    request(CMD_DATA, 6'd0, 1'b0, DP_STOP, 10'd0, 8'h00);
    request(CMD_ISSUE, 6'd24, 1'b0, DP_WRITE, 10'd1, TOK_MULTI);
    push(rand_item(CMD_ISSUE));
    push(rand_item(CMD_REL));
    push(rand_item(CMD_ISSUE));
    push(rand_item(CMD_ISSUE));
    push(rand_item(CMD_REL));

    configure(8'd1, 8'd1);
    for (k = 0; k < 7; k++) random_request();
    configure(8'd255, 8'd255);
    @(posedge clk_i);
    want_hold = 1'b1;
    for (k = 0; k < 7; k++) random_request();
    configure(8'd3, 8'd5);
    for (k = 0; k < 7; k++) random_request();
    configure(8'd1, 8'd255);
    for (k = 0; k < 7; k++) random_request();
    configure(8'd255, 8'd1);
    quiet = 1'b1;
    for (k = 0; k < 7; k++) random_request();

    wait_c = 0;
    while ((pending_xfers.size() != 0 || predicted_results.size() != 0) && wait_c < 20000) begin
      @(posedge clk_i);
      wait_c++;
    end
    repeat (5) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $realtime, predicted_results.size());
    end
    $display("covered %0d transfers in and %0d out, %0d finished requests, %0d block bytes",
             n_in, n_out, n_done, n_reads);
    $display("timeout settings swept from 1 to 255, with read, write and stop phases");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
